// ===== src/olrm_pkg.sv =====
// Shared constants and control types for the ordered list remove-matching core.
`timescale 1ns / 1ps
`default_nettype none
package olrm_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int CMD_W      = 2;
  localparam int VALUE_W    = 32;
  localparam int INDEX_W    = 4;
  localparam int STATUS_W   = 3;
  localparam int REMOVED_W  = 5;
  localparam int LENGTH_W   = 5;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 48;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic eval;
    logic scan_step;
    logic commit;
    logic load_out;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_scan;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/olrm_ctrl.sv =====
// Command sequencer for the ordered list remove-matching core.
`timescale 1ns / 1ps
`default_nettype none
module olrm_ctrl import olrm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_axis_tvalid,
  output logic          s_axis_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next    = state;
    ctl           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          ctl.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.eval   = 1'b1;
        state_next = stat.is_scan ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          ctl.commit = 1'b1;
          state_next = S_FINISH;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/olrm_dp.sv =====
// Datapath: entry store, length, delete compaction scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module olrm_dp import olrm_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dp_cmd_t              ctl,
  output dp_stat_t                  stat,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0]      m_axis_tdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

  logic [CMD_W-1:0]          req_cmd;
  logic signed [VALUE_W-1:0] req_value;
  logic [INDEX_W-1:0]        req_index;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata;

  logic [CW-1:0]       count;
  logic [CW-1:0]       rd_ptr;
  logic [CW-1:0]       keep;
  logic [CW-1:0]       removed;
  logic                pend;
  logic [STATUS_W-1:0] res_status;
  logic                res_rd_ok;

  logic               full;
  logic               empty;
  logic               idx_ok;
  logic               we;
  logic               re;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [VALUE_W-1:0] wdata;
  logic               more;
  logic               hit;

  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign idx_ok = (IW'(req_index) < IW'(count));
  assign more   = (rd_ptr != count);
  assign hit    = (rdata == req_value);

  assign stat.is_scan   = (req_cmd == CMD_DELETE) && !empty;
  assign stat.scan_done = !more && !pend;
  assign stat.out_free  = !m_axis_tvalid || m_axis_tready;

  // one store write and one store read per cycle
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = req_value;
    if (ctl.eval) begin
      case (req_cmd)
        CMD_APPEND: begin
          if (!full) begin
            we    = 1'b1;
            waddr = count[AW-1:0];
          end
        end
        CMD_READ: begin
          if (!empty && idx_ok) begin
            re    = 1'b1;
            raddr = AW'(req_index);
          end
        end
        default: ;
      endcase
    end
    if (ctl.scan_step) begin
      if (more) begin
        re    = 1'b1;
        raddr = rd_ptr[AW-1:0];
      end
      // survivors slide down; keep always trails the read pointer
      if (pend && !hit) begin
        we    = 1'b1;
        waddr = keep[AW-1:0];
        wdata = rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      req_cmd   <= s_axis_tdata[1:0];
      req_value <= s_axis_tdata[33:2];
      req_index <= s_axis_tdata[37:34];
    end
    if (ctl.load_out) begin
      m_axis_tdata <= {3'b000,
                       (res_rd_ok ? rdata : {VALUE_W{1'b0}}),
                       LENGTH_W'(count),
                       REMOVED_W'(removed),
                       res_status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      rd_ptr        <= '0;
      keep          <= '0;
      removed       <= '0;
      pend          <= 1'b0;
      res_status    <= ST_OK;
      res_rd_ok     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (ctl.eval) begin
        rd_ptr    <= '0;
        keep      <= '0;
        removed   <= '0;
        pend      <= 1'b0;
        res_rd_ok <= 1'b0;
        res_status <= ST_OK;
        case (req_cmd)
          CMD_APPEND: begin
            if (full) begin
              res_status <= ST_FULL;
            end else begin
              count <= count + CW'(1);
            end
          end
          CMD_DELETE: begin
            if (empty) begin
              res_status <= ST_EMPTY;
            end
          end
          CMD_READ: begin
            if (empty) begin
              res_status <= ST_EMPTY;
            end else if (!idx_ok) begin
              res_status <= ST_RANGE;
            end else begin
              res_rd_ok <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (ctl.scan_step) begin
        pend <= more;
        if (more) begin
          rd_ptr <= rd_ptr + CW'(1);
        end
        if (pend) begin
          if (hit) begin
            removed <= removed + CW'(1);
          end else begin
            keep <= keep + CW'(1);
          end
        end
      end
      if (ctl.commit) begin
        count <= keep;
        if (removed == '0) begin
          res_status <= ST_NOT_FOUND;
        end
      end
      if (ctl.load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/ordered_list_remove_matching_core.sv =====
// Append, read and delete-all-matching on a bounded ordered list of DEPTH entries.
// Append, read, error and no-op requests pass the execute and finish states; then the result is registered.
// Delete scans the list one entry per cycle in the scan state, then commits the new list length.
// One request is in work at a time; a finished result waits in the output register.
// Synchronous active-high reset empties the list; stored entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module ordered_list_remove_matching_core import olrm_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // cmd[1:0], value[33:2], index[37:34], zero pad[39:38]
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // status[2:0], removed_count[7:3], list_length[12:8], read_value[44:13], zero pad[47:45]
  output logic [M_TDATA_W-1:0]      m_axis_tdata
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  olrm_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .ctl           (ctl)
  );

  olrm_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire
